FILE: sv/rfps_pkg.sv
package rfps_pkg;

  // Field widths
  localparam int unsigned MAG_W  = 23;
  localparam int unsigned SVAL_W = 24;
  localparam int unsigned MACH_W = 11;
  localparam int unsigned TIME_W = 32;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOOST_ACCEL  = 4'd0,
    CFG_BOOST_SPEED  = 4'd1,
    CFG_COAST_ACCEL  = 4'd2,
    CFG_LAUNCH_ALT   = 4'd3,
    CFG_REEFED_ALT   = 4'd4,
    CFG_LANDING_BAND = 4'd5,
    CFG_MACH_TRANS   = 4'd6,
    CFG_MACH_SUPER   = 4'd7
  } cfg_idx_t;

  // Register reset values
  localparam logic [MAG_W-1:0]  RST_BOOST_ACCEL  = 23'd7680;
  localparam logic [MAG_W-1:0]  RST_BOOST_SPEED  = 23'd2560;
  localparam logic [SVAL_W-1:0] RST_COAST_ACCEL  = 24'd0;
  localparam logic [MAG_W-1:0]  RST_LAUNCH_ALT   = 23'd768;
  localparam logic [MAG_W-1:0]  RST_REEFED_ALT   = 23'd51200;
  localparam logic [MAG_W-1:0]  RST_LANDING_BAND = 23'd512;
  localparam logic [MACH_W-1:0] RST_MACH_TRANS   = 11'd205;
  localparam logic [MACH_W-1:0] RST_MACH_SUPER   = 11'd307;

  typedef enum logic [3:0] {
    PH_IDLE         = 4'd0,
    PH_AWAIT_INIT   = 4'd1,
    PH_INITIATED    = 4'd2,
    PH_AWAIT_LAUNCH = 4'd3,
    PH_BOOST        = 4'd4,
    PH_COAST        = 4'd5,
    PH_MAIN         = 4'd6,
    PH_REEFED       = 4'd7,
    PH_LANDED       = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    RG_SUBSONIC   = 2'd0,
    RG_TRANSONIC  = 2'd1,
    RG_SUPERSONIC = 2'd2
  } regime_t;

  typedef enum logic [1:0] {
    PYRO_NONE = 2'd0,
    PYRO_ONE  = 2'd1,
    PYRO_TWO  = 2'd2
  } pyro_t;

  // One tick of flight data
  typedef struct packed {
    logic [MAG_W-1:0]         accel_magnitude;
    logic [MAG_W-1:0]         speed_magnitude;
    logic signed [SVAL_W-1:0] vertical_accel;
    logic signed [SVAL_W-1:0] vertical_velocity;
    logic signed [SVAL_W-1:0] altitude;
    logic [MACH_W-1:0]        mach;
    logic                     thrust_active;
    logic                     cmd_initiate;
    logic                     cmd_launch;
    logic                     init_done;
    logic [MAG_W-1:0]         gravity_estimate;
    logic [TIME_W-1:0]        time_ms;
  } tick_t;

  // One result
  typedef struct packed {
    phase_t            phase;
    regime_t           speed_regime;
    logic              start_init;
    pyro_t             pyro_fire;
    logic              launched;
    logic              burned_out;
    logic              apogee_seen;
    logic              touched_down;
    logic [TIME_W-1:0] liftoff_ms;
    logic [TIME_W-1:0] apogee_ms;
  } result_t;

endpackage

FILE: sv/rfps_if.sv
// Flight data tick channel
interface rfps_tick_if import rfps_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [MAG_W-1:0]         accel_magnitude;
  logic [MAG_W-1:0]         speed_magnitude;
  logic signed [SVAL_W-1:0] vertical_accel;
  logic signed [SVAL_W-1:0] vertical_velocity;
  logic signed [SVAL_W-1:0] altitude;
  logic [MACH_W-1:0]        mach;
  logic                     thrust_active;
  logic                     cmd_initiate;
  logic                     cmd_launch;
  logic                     init_done;
  logic [MAG_W-1:0]         gravity_estimate;
  logic [TIME_W-1:0]        time_ms;

  modport source (
    output valid, accel_magnitude, speed_magnitude, vertical_accel, vertical_velocity,
           altitude, mach, thrust_active, cmd_initiate, cmd_launch, init_done,
           gravity_estimate, time_ms,
    input  ready
  );
  modport sink (
    input  valid, accel_magnitude, speed_magnitude, vertical_accel, vertical_velocity,
           altitude, mach, thrust_active, cmd_initiate, cmd_launch, init_done,
           gravity_estimate, time_ms,
    output ready
  );
endinterface

// Result channel
interface rfps_result_if import rfps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [3:0]        phase;
  logic [1:0]        speed_regime;
  logic              start_init;
  logic [1:0]        pyro_fire;
  logic              launched;
  logic              burned_out;
  logic              apogee_seen;
  logic              touched_down;
  logic [TIME_W-1:0] liftoff_ms;
  logic [TIME_W-1:0] apogee_ms;

  modport source (
    output valid, phase, speed_regime, start_init, pyro_fire, launched, burned_out,
           apogee_seen, touched_down, liftoff_ms, apogee_ms,
    input  ready
  );
  modport sink (
    input  valid, phase, speed_regime, start_init, pyro_fire, launched, burned_out,
           apogee_seen, touched_down, liftoff_ms, apogee_ms,
    output ready
  );
endinterface

// Register write channel
interface rfps_cfg_if import rfps_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/rocket_flight_phase_sequencer.sv
// Flight phase sequencer: one flight data tick in, one status result out per request.
// A tick is taken every clock cycle unless the result register is stalled; each tick
// passes the input register and then the result register, and a stalled result register
// holds the input register so back-pressure never drops a tick. The rate is set by the
// single compare pass that steps the phase and Mach regime registers. Registers must be
// written through the cfg channel (always ready) only while no tick is in flight; the
// block itself does not enforce this. Indexes outside the list are ignored. After reset
// all thresholds take their default values, the phase is idle and the regime subsonic.
module rocket_flight_phase_sequencer import rfps_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  rfps_tick_if.sink      tick,
  rfps_result_if.source  result,
  rfps_cfg_if.sink       cfg
);

  // Configuration registers
  logic [MAG_W-1:0]         boost_accel_thr;
  logic [MAG_W-1:0]         boost_speed_thr;
  logic signed [SVAL_W-1:0] coast_accel_thr;
  logic [MAG_W-1:0]         launch_min_alt;
  logic [MAG_W-1:0]         reefed_alt;
  logic [MAG_W-1:0]         landing_band;
  logic [MACH_W-1:0]        mach_trans;
  logic [MACH_W-1:0]        mach_super;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      boost_accel_thr <= RST_BOOST_ACCEL;
      boost_speed_thr <= RST_BOOST_SPEED;
      coast_accel_thr <= RST_COAST_ACCEL;
      launch_min_alt  <= RST_LAUNCH_ALT;
      reefed_alt      <= RST_REEFED_ALT;
      landing_band    <= RST_LANDING_BAND;
      mach_trans      <= RST_MACH_TRANS;
      mach_super      <= RST_MACH_SUPER;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_BOOST_ACCEL:  boost_accel_thr <= cfg.data[MAG_W-1:0];
        CFG_BOOST_SPEED:  boost_speed_thr <= cfg.data[MAG_W-1:0];
        CFG_COAST_ACCEL:  coast_accel_thr <= cfg.data[SVAL_W-1:0];
        CFG_LAUNCH_ALT:   launch_min_alt  <= cfg.data[MAG_W-1:0];
        CFG_REEFED_ALT:   reefed_alt      <= cfg.data[MAG_W-1:0];
        CFG_LANDING_BAND: landing_band    <= cfg.data[MAG_W-1:0];
        CFG_MACH_TRANS:   mach_trans      <= cfg.data[MACH_W-1:0];
        CFG_MACH_SUPER:   mach_super      <= cfg.data[MACH_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: input register advances when the result register is free
  logic  in_valid;
  tick_t in_q;
  logic  out_valid;
  result_t out_q;
  logic  advance;

  assign advance    = in_valid && (!out_valid || result.ready);
  assign tick.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (tick.ready) begin
      in_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      in_q.accel_magnitude   <= tick.accel_magnitude;
      in_q.speed_magnitude   <= tick.speed_magnitude;
      in_q.vertical_accel    <= tick.vertical_accel;
      in_q.vertical_velocity <= tick.vertical_velocity;
      in_q.altitude          <= tick.altitude;
      in_q.mach              <= tick.mach;
      in_q.thrust_active     <= tick.thrust_active;
      in_q.cmd_initiate      <= tick.cmd_initiate;
      in_q.cmd_launch        <= tick.cmd_launch;
      in_q.init_done         <= tick.init_done;
      in_q.gravity_estimate  <= tick.gravity_estimate;
      in_q.time_ms           <= tick.time_ms;
    end
  end

  // Sequencer state
  phase_t            phase,  phase_next;
  regime_t           regime, regime_next;
  logic [3:0]        flags,  flags_next;   // launch, burnout, apogee, landed
  logic [TIME_W-1:0] liftoff_stamp, liftoff_stamp_next;
  logic [TIME_W-1:0] apogee_stamp,  apogee_stamp_next;
  logic              start_init;
  pyro_t             pyro;

  // Threshold compares; the altitude and landing band compares use 25-bit signed arithmetic
  logic signed [SVAL_W:0] alt_x, amag_x, band_lo, band_hi;
  logic launch_hit, burnout_hit, apogee_hit, reef_hit, land_hit;

  always_comb begin
    alt_x   = {in_q.altitude[SVAL_W-1], in_q.altitude};
    amag_x  = {2'b00, in_q.accel_magnitude};
    band_lo = $signed({2'b00, in_q.gravity_estimate}) - $signed({2'b00, landing_band});
    band_hi = $signed({2'b00, in_q.gravity_estimate}) + $signed({2'b00, landing_band});
    launch_hit  = ((in_q.accel_magnitude > boost_accel_thr) &&
                   (alt_x > $signed({2'b00, launch_min_alt}))) ||
                  (in_q.speed_magnitude > boost_speed_thr);
    burnout_hit = (in_q.vertical_accel < coast_accel_thr) && !in_q.thrust_active;
    apogee_hit  = in_q.vertical_velocity[SVAL_W-1];
    reef_hit    = alt_x < $signed({2'b00, reefed_alt});
    land_hit    = (amag_x > band_lo) && (amag_x < band_hi);
  end

  // Phase step
  always_comb begin
    phase_next         = phase;
    flags_next         = flags;
    liftoff_stamp_next = liftoff_stamp;
    apogee_stamp_next  = apogee_stamp;
    start_init         = 1'b0;
    pyro               = PYRO_NONE;
    unique case (phase)
      PH_IDLE: begin
        if (in_q.cmd_initiate) begin
          phase_next = PH_AWAIT_INIT;
          start_init = 1'b1;
        end
      end
      PH_AWAIT_INIT: begin
        if (in_q.init_done) phase_next = PH_INITIATED;
      end
      PH_INITIATED: begin
        if (in_q.cmd_launch) phase_next = PH_AWAIT_LAUNCH;
      end
      PH_AWAIT_LAUNCH: begin
        if (launch_hit) begin
          phase_next         = PH_BOOST;
          flags_next[0]      = 1'b1;
          liftoff_stamp_next = in_q.time_ms;
        end
      end
      PH_BOOST: begin
        if (burnout_hit) begin
          phase_next    = PH_COAST;
          flags_next[1] = 1'b1;
        end
      end
      PH_COAST: begin
        if (apogee_hit) begin
          phase_next        = PH_MAIN;
          pyro              = PYRO_TWO;
          flags_next[2]     = 1'b1;
          apogee_stamp_next = in_q.time_ms;
        end
      end
      PH_MAIN: begin
        if (reef_hit) begin
          phase_next = PH_REEFED;
          pyro       = PYRO_ONE;
        end
      end
      PH_REEFED: begin
        if (land_hit) begin
          phase_next    = PH_LANDED;
          flags_next[3] = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Mach regime with hysteresis; the subsonic check wins in transonic
  always_comb begin
    regime_next = regime;
    case (regime)
      RG_SUBSONIC: begin
        if (in_q.mach > mach_trans) regime_next = RG_TRANSONIC;
      end
      RG_TRANSONIC: begin
        if (in_q.mach > mach_super) regime_next = RG_SUPERSONIC;
        if (in_q.mach < mach_trans) regime_next = RG_SUBSONIC;
      end
      RG_SUPERSONIC: begin
        if (in_q.mach < mach_super) regime_next = RG_TRANSONIC;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      regime        <= RG_SUBSONIC;
      flags         <= '0;
      liftoff_stamp <= '0;
      apogee_stamp  <= '0;
    end else if (advance) begin
      phase         <= phase_next;
      regime        <= regime_next;
      flags         <= flags_next;
      liftoff_stamp <= liftoff_stamp_next;
      apogee_stamp  <= apogee_stamp_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_q.phase        <= phase_next;
      out_q.speed_regime <= regime_next;
      out_q.start_init   <= start_init;
      out_q.pyro_fire    <= pyro;
      out_q.launched     <= flags_next[0];
      out_q.burned_out   <= flags_next[1];
      out_q.apogee_seen  <= flags_next[2];
      out_q.touched_down <= flags_next[3];
      out_q.liftoff_ms   <= liftoff_stamp_next;
      out_q.apogee_ms    <= apogee_stamp_next;
    end
  end

  assign result.valid        = out_valid;
  assign result.phase        = out_q.phase;
  assign result.speed_regime = out_q.speed_regime;
  assign result.start_init   = out_q.start_init;
  assign result.pyro_fire    = out_q.pyro_fire;
  assign result.launched     = out_q.launched;
  assign result.burned_out   = out_q.burned_out;
  assign result.apogee_seen  = out_q.apogee_seen;
  assign result.touched_down = out_q.touched_down;
  assign result.liftoff_ms   = out_q.liftoff_ms;
  assign result.apogee_ms    = out_q.apogee_ms;

endmodule

FILE: sv/rfps_checker.sv
module rfps_checker import rfps_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] phase,
  input logic [1:0] speed_regime,
  input logic       start_init,
  input logic [1:0] pyro_fire,
  input logic       launched,
  input logic       apogee_seen
);

  // Init pulse only on the tick that enters awaiting init
  a_start_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid && start_init |-> phase == PH_AWAIT_INIT)
    else $error("start_init outside awaiting init");

  // Apogee pyro comes with main descent and the apogee flag
  a_pyro_two: assert property (@(posedge clk) disable iff (rst)
    out_valid && pyro_fire == PYRO_TWO |-> phase == PH_MAIN && apogee_seen)
    else $error("pyro two without apogee");

  // Any flight phase implies the launch flag is set
  a_launched: assert property (@(posedge clk) disable iff (rst)
    out_valid && phase >= PH_BOOST && phase <= PH_LANDED |-> launched)
    else $error("flight phase without launch flag");

  // Regime code stays within the three defined regimes
  a_regime: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> speed_regime <= RG_SUPERSONIC)
    else $error("undefined speed regime");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(phase) && $stable(pyro_fire))
    else $error("stalled result changed");

endmodule

bind rocket_flight_phase_sequencer rfps_checker u_rfps_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .phase        (result.phase),
  .speed_regime (result.speed_regime),
  .start_init   (result.start_init),
  .pyro_fire    (result.pyro_fire),
  .launched     (result.launched),
  .apogee_seen  (result.apogee_seen)
);

FILE: bench/tb_rocket_flight_phase_sequencer.sv
`timescale 1ns / 100ps

module tb_rocket_flight_phase_sequencer;
  import rfps_pkg::*;

  localparam int MAG_MAX  = (1 << MAG_W) - 1;
  localparam int S_MAX    = (1 << (SVAL_W - 1)) - 1;
  localparam int S_MIN    = -(1 << (SVAL_W - 1));
  localparam int MACH_MAX = (1 << MACH_W) - 1;
  localparam int CFG_SLOTS = int'(CFG_MACH_SUPER) + 1;

  localparam int RANDOM_TICKS  = 1480;
  localparam int SETTING_EVERY = 250;
  localparam int GO_ODDS       = 100;  // one in this many shaped ticks fires the transition
  localparam int NOISE_PCT     = 3;
  localparam int IDLE_PCT      = 37;
  localparam int CALM_FROM     = 600;
  localparam int CALM_TO       = 900;
  localparam int SETTLE_CYCLES = 3;
  localparam int DRAIN_CYCLES  = 20;
  localparam int MAX_REPORTS   = 200;
  localparam int LIMIT_NS      = 2000000;

  // Threshold registers as plain integers
  typedef struct {
    int boost_accel;
    int boost_speed;
    int coast_accel;
    int launch_alt;
    int reefed_alt;
    int band;
    int mach_lo;
    int mach_hi;
  } limits_t;

  typedef struct packed {
    phase_t            phase;
    regime_t           regime;
    logic              launched;
    logic              burned_out;
    logic              apogee_seen;
    logic              touched_down;
    logic [TIME_W-1:0] liftoff_ms;
    logic [TIME_W-1:0] apogee_ms;
  } flight_t;

  // One uplink request: a flight tick or a register write
  typedef struct {
    bit                    is_write;
    tick_t                 item;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } op_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rfps_tick_if   tick_ch ();
  rfps_result_if res_ch ();
  rfps_cfg_if    cfg_ch ();

  rocket_flight_phase_sequencer dut (
    .clk    (clk),
    .rst    (rst),
    .tick   (tick_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  // Bus drive registers, all known from time zero
  logic                  tick_go   = 1'b0;
  tick_t                 tick_cur  = '0;
  logic                  cfg_go    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  res_ready = 1'b0;

  assign tick_ch.valid             = tick_go;
  assign tick_ch.accel_magnitude   = tick_cur.accel_magnitude;
  assign tick_ch.speed_magnitude   = tick_cur.speed_magnitude;
  assign tick_ch.vertical_accel    = tick_cur.vertical_accel;
  assign tick_ch.vertical_velocity = tick_cur.vertical_velocity;
  assign tick_ch.altitude          = tick_cur.altitude;
  assign tick_ch.mach              = tick_cur.mach;
  assign tick_ch.thrust_active     = tick_cur.thrust_active;
  assign tick_ch.cmd_initiate      = tick_cur.cmd_initiate;
  assign tick_ch.cmd_launch        = tick_cur.cmd_launch;
  assign tick_ch.init_done         = tick_cur.init_done;
  assign tick_ch.gravity_estimate  = tick_cur.gravity_estimate;
  assign tick_ch.time_ms           = tick_cur.time_ms;
  assign cfg_ch.valid              = cfg_go;
  assign cfg_ch.index              = cfg_idx;
  assign cfg_ch.data               = cfg_data;
  assign res_ch.ready              = res_ready;

  op_t     uplink_q[$];
  result_t status_due[$];
  flight_t plan_st, track_st;
  limits_t plan_lim, track_lim;
  bit      tick_took = 1'b0;
  bit      cfg_took  = 1'b0;
  int      quiet_cycles = 0;
  int      ticks_done = 0;
  int      writes_done = 0;
  int      results_seen = 0;
  int      fail_count = 0;

  always #2 clk = ~clk;

  initial begin
    repeat (12) @(negedge clk);
    rst <= 1'b0;
  end

  initial begin
    #LIMIT_NS;
    $display("Timeout with %0d ticks sent and %0d status results pending",
             ticks_done, status_due.size());
    $display("Some tests failed");
    $finish;
  end

  function automatic limits_t limits_at_reset();
    limits_t l;
    l.boost_accel = int'(RST_BOOST_ACCEL);
    l.boost_speed = int'(RST_BOOST_SPEED);
    l.coast_accel = int'($signed(RST_COAST_ACCEL));
    l.launch_alt  = int'(RST_LAUNCH_ALT);
    l.reefed_alt  = int'(RST_REEFED_ALT);
    l.band        = int'(RST_LANDING_BAND);
    l.mach_lo     = int'(RST_MACH_TRANS);
    l.mach_hi     = int'(RST_MACH_SUPER);
    return l;
  endfunction

  function automatic flight_t on_pad();
    flight_t s;
    s.phase        = PH_IDLE;
    s.regime       = RG_SUBSONIC;
    s.launched     = 1'b0;
    s.burned_out   = 1'b0;
    s.apogee_seen  = 1'b0;
    s.touched_down = 1'b0;
    s.liftoff_ms   = '0;
    s.apogee_ms    = '0;
    return s;
  endfunction

  // Register write; unknown indexes leave everything alone
  function automatic void load_limit(inout limits_t l, input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] d);
    case (idx)
      CFG_BOOST_ACCEL:  l.boost_accel = int'(d[MAG_W-1:0]);
      CFG_BOOST_SPEED:  l.boost_speed = int'(d[MAG_W-1:0]);
      CFG_COAST_ACCEL:  l.coast_accel = int'($signed(d));
      CFG_LAUNCH_ALT:   l.launch_alt  = int'(d[MAG_W-1:0]);
      CFG_REEFED_ALT:   l.reefed_alt  = int'(d[MAG_W-1:0]);
      CFG_LANDING_BAND: l.band        = int'(d[MAG_W-1:0]);
      CFG_MACH_TRANS:   l.mach_lo     = int'(d[MACH_W-1:0]);
      CFG_MACH_SUPER:   l.mach_hi     = int'(d[MACH_W-1:0]);
      default: ;
    endcase
  endfunction

  // One flight tick: phase step, then Mach regime with hysteresis
  function automatic result_t advance_flight(inout flight_t s, input limits_t l,
                                             input tick_t t);
    result_t r;
    int a, v, az, vz, alt, g, m;
    a   = int'(t.accel_magnitude);
    v   = int'(t.speed_magnitude);
    az  = int'($signed(t.vertical_accel));
    vz  = int'($signed(t.vertical_velocity));
    alt = int'($signed(t.altitude));
    g   = int'(t.gravity_estimate);
    m   = int'(t.mach);
    r.start_init = 1'b0;
    r.pyro_fire  = PYRO_NONE;
    case (s.phase)
      PH_IDLE: if (t.cmd_initiate) begin
        s.phase = PH_AWAIT_INIT;
        r.start_init = 1'b1;
      end
      PH_AWAIT_INIT: if (t.init_done) s.phase = PH_INITIATED;
      PH_INITIATED: if (t.cmd_launch) s.phase = PH_AWAIT_LAUNCH;
      PH_AWAIT_LAUNCH: if ((a > l.boost_accel && alt > l.launch_alt) || v > l.boost_speed) begin
        s.phase = PH_BOOST;
        s.launched = 1'b1;
        s.liftoff_ms = t.time_ms;
      end
      PH_BOOST: if (az < l.coast_accel && !t.thrust_active) begin
        s.phase = PH_COAST;
        s.burned_out = 1'b1;
      end
      PH_COAST: if (vz < 0) begin
        s.phase = PH_MAIN;
        r.pyro_fire = PYRO_TWO;
        s.apogee_seen = 1'b1;
        s.apogee_ms = t.time_ms;
      end
      PH_MAIN: if (alt < l.reefed_alt) begin
        s.phase = PH_REEFED;
        r.pyro_fire = PYRO_ONE;
      end
      PH_REEFED: if (a > g - l.band && a < g + l.band) begin
        s.phase = PH_LANDED;
        s.touched_down = 1'b1;
      end
      default: ;
    endcase
    case (s.regime)
      RG_SUBSONIC: if (m > l.mach_lo) s.regime = RG_TRANSONIC;
      RG_TRANSONIC: begin
        if (m > l.mach_hi) s.regime = RG_SUPERSONIC;
        // dropping back below the lower boundary wins
        if (m < l.mach_lo) s.regime = RG_SUBSONIC;
      end
      RG_SUPERSONIC: if (m < l.mach_hi) s.regime = RG_TRANSONIC;
      default: ;
    endcase
    r.phase        = s.phase;
    r.speed_regime = s.regime;
    r.launched     = s.launched;
    r.burned_out   = s.burned_out;
    r.apogee_seen  = s.apogee_seen;
    r.touched_down = s.touched_down;
    r.liftoff_ms   = s.liftoff_ms;
    r.apogee_ms    = s.apogee_ms;
    return r;
  endfunction

  // Value in [lo, hi], often hugging lo or hi
  function automatic int pick(int lo, int hi);
    int span, hug;
    span = hi - lo;
    hug = (span < 3) ? span : 3;
    case ($urandom_range(0, 3))
      0: return lo + int'($urandom_range(0, hug));
      1: return hi - int'($urandom_range(0, hug));
      default: return lo + int'($urandom_range(0, span));
    endcase
  endfunction

  function automatic tick_t noise_tick();
    logic [191:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return raw[$bits(tick_t)-1:0];
  endfunction

  function automatic void push_tick(tick_t t);
    op_t op;
    op.is_write = 1'b0;
    op.item = t;
    op.idx = '0;
    op.data = '0;
    uplink_q.push_back(op);
    void'(advance_flight(plan_st, plan_lim, t));
  endfunction

  function automatic void push_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    op_t op;
    op.is_write = 1'b1;
    op.item = '0;
    op.idx = idx;
    op.data = d;
    uplink_q.push_back(op);
    load_limit(plan_lim, idx, d);
  endfunction

  // Idle-phase tick with a chosen Mach value
  function automatic void push_idle_mach(int m);
    tick_t t;
    t = noise_tick();
    t.cmd_initiate = 1'b0;
    t.mach = MACH_W'(m);
    push_tick(t);
  endfunction

  task automatic cmp_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      if (fail_count < MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Driver: uplink requests go out at the falling edge
  always @(negedge clk) begin : drive
    op_t                   op;
    logic                  nx_tv, nx_cv;
    tick_t                 nx_t;
    logic [CFG_IDX_W-1:0]  nx_idx;
    logic [CFG_DATA_W-1:0] nx_dat;
    bit                    calm;
    calm   = ticks_done >= CALM_FROM && ticks_done < CALM_TO;
    nx_tv  = tick_go && !tick_took;
    nx_cv  = cfg_go && !cfg_took;
    nx_t   = tick_cur;
    nx_idx = cfg_idx;
    nx_dat = cfg_data;
    if (status_due.size() == 0 && !nx_tv && !nx_cv) quiet_cycles++;
    else quiet_cycles = 0;
    if (!rst && !nx_tv && !nx_cv && uplink_q.size() > 0) begin
      if (uplink_q[0].is_write) begin
        // register writes only once the pipeline has drained
        if (quiet_cycles >= SETTLE_CYCLES) begin
          op = uplink_q.pop_front();
          nx_cv = 1'b1;
          nx_idx = op.idx;
          nx_dat = op.data;
          quiet_cycles = 0;
        end
      end else if (calm || $urandom_range(0, 99) >= IDLE_PCT) begin
        op = uplink_q.pop_front();
        nx_tv = 1'b1;
        nx_t = op.item;
      end
    end
    tick_go   <= nx_tv;
    tick_cur  <= nx_t;
    cfg_go    <= nx_cv;
    cfg_idx   <= nx_idx;
    cfg_data  <= nx_dat;
    res_ready <= calm || $urandom_range(0, 99) >= IDLE_PCT;
  end

  // Monitor: handshakes sampled at the rising edge
  always @(posedge clk) begin : watch
    result_t want;
    tick_took = tick_go && tick_ch.ready;
    cfg_took  = cfg_go && cfg_ch.ready;
    if (!rst) begin
      if (res_ch.valid && res_ready) begin
        results_seen++;
        if (status_due.size() == 0) begin
          $display("%0t ns: status result with none expected, expected nothing, got phase %0d",
                   $time, res_ch.phase);
          fail_count++;
        end else begin
          want = status_due.pop_front();
          cmp_field("phase", 32'(want.phase), 32'(res_ch.phase));
          cmp_field("speed_regime", 32'(want.speed_regime), 32'(res_ch.speed_regime));
          cmp_field("start_init", 32'(want.start_init), 32'(res_ch.start_init));
          cmp_field("pyro_fire", 32'(want.pyro_fire), 32'(res_ch.pyro_fire));
          cmp_field("launched", 32'(want.launched), 32'(res_ch.launched));
          cmp_field("burned_out", 32'(want.burned_out), 32'(res_ch.burned_out));
          cmp_field("apogee_seen", 32'(want.apogee_seen), 32'(res_ch.apogee_seen));
          cmp_field("touched_down", 32'(want.touched_down), 32'(res_ch.touched_down));
          cmp_field("liftoff_ms", want.liftoff_ms, res_ch.liftoff_ms);
          cmp_field("apogee_ms", want.apogee_ms, res_ch.apogee_ms);
        end
      end
      if (cfg_took) begin
        load_limit(track_lim, cfg_idx, cfg_data);
        writes_done++;
      end
      if (tick_took) begin
        status_due.push_back(advance_flight(track_st, track_lim, tick_cur));
        ticks_done++;
      end
    end
  end

  // Stimulus: directed ticks and register writes on the pad, then one shaped random flight
  initial begin : stimulus
    tick_t                 t;
    logic [CFG_DATA_W-1:0] d;
    int                    walk[$];
    int                    n, r, roll, m, lo, hi;
    int                    a, v, az, vz, alt, g;
    bit                    go;
    track_st  = on_pad();
    plan_st   = on_pad();
    track_lim = limits_at_reset();
    plan_lim  = limits_at_reset();

    // field extremes while idle
    t = '0;
    push_tick(t);
    t = '1;
    t.cmd_initiate = 1'b0;
    push_tick(t);
    t = noise_tick();
    t.cmd_initiate = 1'b0;
    t.vertical_accel = SVAL_W'(S_MIN);
    t.vertical_velocity = SVAL_W'(S_MIN);
    t.altitude = SVAL_W'(S_MIN);
    t.accel_magnitude = '0;
    t.mach = '0;
    push_tick(t);
    t = noise_tick();
    t.cmd_initiate = 1'b0;
    t.vertical_accel = SVAL_W'(S_MAX);
    t.vertical_velocity = SVAL_W'(S_MAX);
    t.altitude = SVAL_W'(S_MAX);
    t.speed_magnitude = '1;
    t.mach = '0;
    push_tick(t);

    // regime walk across both boundaries, exact boundary values hold
    m = int'(RST_MACH_TRANS);
    n = int'(RST_MACH_SUPER);
    walk = '{m, m + 1, n, n + 1, n, n - 1, m, m - 1};
    foreach (walk[i]) push_idle_mach(walk[i]);

    // boundaries swapped: the drop to subsonic must win from transonic
    push_write(CFG_MACH_TRANS, CFG_DATA_W'(400));
    push_write(CFG_MACH_SUPER, CFG_DATA_W'(100));
    walk = '{401, 300, 401, 401, 50};
    foreach (walk[i]) push_idle_mach(walk[i]);

    // writes to unused indexes are dropped
    push_write(CFG_IDX_W'(CFG_SLOTS), '1);
    push_write('1, CFG_DATA_W'($urandom));

    for (n = 0; n < RANDOM_TICKS; n++) begin
      // new register settings every so often, all of them at the start
      if (n % SETTING_EVERY == 0) begin
        for (r = 0; r < CFG_SLOTS; r++) begin
          if (n == 0 || $urandom_range(0, 1) == 1) begin
            roll = $urandom_range(0, 5);
            if (roll == 0) d = '0;
            else if (roll == 1) d = '1;
            else if (roll == 2) d = $urandom_range(0, 1) ? CFG_DATA_W'(S_MIN) : CFG_DATA_W'(S_MAX);
            else begin
              case (cfg_idx_t'(r))
                CFG_MACH_TRANS, CFG_MACH_SUPER: d = CFG_DATA_W'($urandom_range(0, MACH_MAX));
                CFG_COAST_ACCEL: d = CFG_DATA_W'(int'($urandom_range(0, 4096)) - 2048);
                CFG_LANDING_BAND: d = CFG_DATA_W'($urandom_range(1, 4096));
                default: d = CFG_DATA_W'($urandom_range(0, 65535));
              endcase
            end
            push_write(CFG_IDX_W'(r), d);
          end
        end
        if ($urandom_range(0, 3) == 0)
          push_write(CFG_IDX_W'($urandom_range(CFG_SLOTS, (1 << CFG_IDX_W) - 1)),
                     CFG_DATA_W'($urandom));
      end

      t = noise_tick();
      if (plan_st.phase != PH_LANDED && $urandom_range(0, 99) >= NOISE_PCT) begin
        go  = $urandom_range(0, GO_ODDS - 1) == 0;
        a   = int'(t.accel_magnitude);
        v   = int'(t.speed_magnitude);
        az  = int'($signed(t.vertical_accel));
        vz  = int'($signed(t.vertical_velocity));
        alt = int'($signed(t.altitude));
        g   = int'(t.gravity_estimate);
        // Mach near one of the boundaries half the time
        if ($urandom_range(0, 1) == 1) begin
          m = ($urandom_range(0, 1) == 1) ? plan_lim.mach_lo : plan_lim.mach_hi;
          m = m - 1 + int'($urandom_range(0, 2));
          if (m < 0) m = 0;
          if (m > MACH_MAX) m = MACH_MAX;
          t.mach = MACH_W'(m);
        end
        case (plan_st.phase)
          PH_IDLE:       t.cmd_initiate = go;
          PH_AWAIT_INIT: t.init_done = go;
          PH_INITIATED:  t.cmd_launch = go;
          PH_AWAIT_LAUNCH: begin
            if (go && plan_lim.boost_speed < MAG_MAX && ($urandom_range(0, 1) == 1 ||
                plan_lim.boost_accel >= MAG_MAX || plan_lim.launch_alt >= S_MAX)) begin
              v = pick(plan_lim.boost_speed + 1, MAG_MAX);
            end else if (go && plan_lim.boost_accel < MAG_MAX && plan_lim.launch_alt < S_MAX) begin
              a = pick(plan_lim.boost_accel + 1, MAG_MAX);
              alt = pick(plan_lim.launch_alt + 1, S_MAX);
            end else begin
              // hold on the pad: speed at or under its limit, one accel gate closed
              v = pick(0, plan_lim.boost_speed);
              if ($urandom_range(0, 1) == 1) a = pick(0, plan_lim.boost_accel);
              else alt = pick(S_MIN, plan_lim.launch_alt);
            end
          end
          PH_BOOST: begin
            if (go && plan_lim.coast_accel > S_MIN) begin
              az = pick(S_MIN, plan_lim.coast_accel - 1);
              t.thrust_active = 1'b0;
            end else if ($urandom_range(0, 1) == 1) begin
              t.thrust_active = 1'b1;
            end else begin
              az = pick(plan_lim.coast_accel, S_MAX);
            end
          end
          PH_COAST: vz = go ? pick(S_MIN, -1) : pick(0, S_MAX);
          PH_MAIN: alt = go ? pick(S_MIN, plan_lim.reefed_alt - 1) : pick(plan_lim.reefed_alt, S_MAX);
          PH_REEFED: begin
            g = pick(0, MAG_MAX);
            lo = g - plan_lim.band;
            hi = g + plan_lim.band;
            if (go && plan_lim.band > 0)
              a = pick((lo + 1 > 0) ? lo + 1 : 0, (hi - 1 < MAG_MAX) ? hi - 1 : MAG_MAX);
            else if (lo >= 0 && ($urandom_range(0, 1) == 1 || hi > MAG_MAX))
              a = pick(0, lo);
            else if (hi <= MAG_MAX)
              a = pick(hi, MAG_MAX);
          end
          default: ;
        endcase
        t.accel_magnitude   = MAG_W'(a);
        t.speed_magnitude   = MAG_W'(v);
        t.vertical_accel    = SVAL_W'(az);
        t.vertical_velocity = SVAL_W'(vz);
        t.altitude          = SVAL_W'(alt);
        t.gravity_estimate  = MAG_W'(g);
      end
      push_tick(t);
    end

    // drain, then report
    while (uplink_q.size() != 0 || tick_go || cfg_go || status_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d flight ticks and %0d register writes, compared %0d status results",
             ticks_done, writes_done, results_seen);
    $display("Flight ended in phase %0d with %0d mismatches", track_st.phase, fail_count);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/rfps_pkg.sv
sv/rfps_if.sv
sv/rocket_flight_phase_sequencer.sv
sv/rfps_checker.sv
bench/tb_rocket_flight_phase_sequencer.sv
